FILE: rtl/plr_pkg.sv
// Package for the pen line rasterizer: result status codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package plr_pkg;

    localparam int COORD_W  = 6;
    localparam int GRID_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_PLOT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MOVE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic accept;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic line_start;
        logic done;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/plr_datapath.sv
// Datapath of the pen line rasterizer: grid register, pen, Bresenham
// stepper and result register. Depends on plr_pkg; driven by plr_ctrl.
`default_nettype none

module plr_datapath #(
    parameter int MAX_GRID = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [plr_pkg::GRID_W-1:0]       cfg_wdata,
    input  wire                              s_action,
    input  wire  signed [7:0]                s_target_x,
    input  wire  signed [7:0]                s_target_y,
    input  wire  plr_pkg::cmd_t              cmd,
    output plr_pkg::sts_t                    sts,
    output logic [plr_pkg::COORD_W-1:0]      m_plot_x,
    output logic [plr_pkg::COORD_W-1:0]      m_plot_y,
    output logic [plr_pkg::STATUS_W-1:0]     m_status,
    output logic                             m_last
);

    localparam logic [plr_pkg::GRID_W-1:0] GRID_CAP = plr_pkg::GRID_W'(MAX_GRID);

    logic [plr_pkg::GRID_W-1:0]   grid_reg;
    logic [plr_pkg::COORD_W-1:0]  pen_x_reg, pen_y_reg;
    logic [plr_pkg::COORD_W-1:0]  tgt_x_reg, tgt_y_reg;
    logic [plr_pkg::COORD_W-1:0]  cur_x_reg, cur_y_reg;
    logic [plr_pkg::COORD_W-1:0]  dx_reg, ady_reg;
    logic                         sx_reg, sy_reg;
    logic signed [8:0]            err_reg;
    logic [plr_pkg::COORD_W-1:0]  cnt_reg;
    logic [plr_pkg::COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [plr_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;

    logic [plr_pkg::GRID_W-1:0]   limit;
    logic                         tgt_ok;
    logic [plr_pkg::COORD_W-1:0]  new_tx, new_ty;
    logic                         new_sx, new_sy;
    logic [plr_pkg::COORD_W-1:0]  new_dx, new_ady;
    logic signed [9:0]            e2, dx_s, ady_s;
    logic signed [8:0]            dx9, ady9, err_next;
    logic                         cond_x, cond_y, step_x, step_y, done;
    logic [plr_pkg::COORD_W-1:0]  x_next, y_next;

    always_comb begin
        limit  = (grid_reg > GRID_CAP) ? GRID_CAP : grid_reg;
        tgt_ok = !s_target_x[7] && (s_target_x[6:0] < limit)
              && !s_target_y[7] && (s_target_y[6:0] < limit);
        new_tx = s_target_x[plr_pkg::COORD_W-1:0];
        new_ty = s_target_y[plr_pkg::COORD_W-1:0];
        new_sx = pen_x_reg < new_tx;
        new_sy = pen_y_reg < new_ty;
        new_dx  = new_sx ? new_tx - pen_x_reg : pen_x_reg - new_tx;
        new_ady = new_sy ? new_ty - pen_y_reg : pen_y_reg - new_ty;

        e2     = {err_reg, 1'b0};
        dx_s   = $signed({4'b0, dx_reg});
        ady_s  = $signed({4'b0, ady_reg});
        dx9    = $signed({3'b0, dx_reg});
        ady9   = $signed({3'b0, ady_reg});
        cond_x = e2 >= -ady_s;
        cond_y = e2 <= dx_s;
        step_x = cond_x && (cur_x_reg != tgt_x_reg);
        step_y = !(cond_x && (cur_x_reg == tgt_x_reg))
              && cond_y && (cur_y_reg != tgt_y_reg);
        done   = (cond_x && (cur_x_reg == tgt_x_reg))
              || (cond_y && (cur_y_reg == tgt_y_reg))
              || (&cnt_reg);
        err_next = err_reg - (step_x ? ady9 : 9'sd0) + (step_y ? dx9 : 9'sd0);
        x_next   = step_x ? (sx_reg ? cur_x_reg + 6'd1 : cur_x_reg - 6'd1) : cur_x_reg;
        y_next   = step_y ? (sy_reg ? cur_y_reg + 6'd1 : cur_y_reg - 6'd1) : cur_y_reg;

        sts.line_start = tgt_ok && s_action;
        sts.done       = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg  <= 7'd64;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else begin
            if (cfg_we) begin
                grid_reg <= cfg_wdata;
            end
            if (cmd.accept && tgt_ok && !s_action) begin
                pen_x_reg <= new_tx;
                pen_y_reg <= new_ty;
            end else if (cmd.emit && done) begin
                pen_x_reg <= tgt_x_reg;
                pen_y_reg <= tgt_y_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tgt_x_reg <= new_tx;
            tgt_y_reg <= new_ty;
            cur_x_reg <= pen_x_reg;
            cur_y_reg <= pen_y_reg;
            dx_reg    <= new_dx;
            ady_reg   <= new_ady;
            sx_reg    <= new_sx;
            sy_reg    <= new_sy;
            err_reg   <= $signed({3'b0, new_dx}) - $signed({3'b0, new_ady});
            cnt_reg   <= '0;
            out_last_reg <= 1'b1;
            if (!tgt_ok) begin
                out_x_reg      <= pen_x_reg;
                out_y_reg      <= pen_y_reg;
                out_status_reg <= plr_pkg::ST_REJECT;
            end else begin
                out_x_reg      <= new_tx;
                out_y_reg      <= new_ty;
                out_status_reg <= plr_pkg::ST_MOVE;
            end
        end else if (cmd.emit) begin
            out_x_reg      <= cur_x_reg;
            out_y_reg      <= cur_y_reg;
            out_status_reg <= plr_pkg::ST_PLOT;
            out_last_reg   <= done;
            cur_x_reg      <= x_next;
            cur_y_reg      <= y_next;
            err_reg        <= err_next;
            cnt_reg        <= cnt_reg + 6'd1;
        end
    end

    assign m_plot_x = out_x_reg;
    assign m_plot_y = out_y_reg;
    assign m_status = out_status_reg;
    assign m_last   = out_last_reg;

    a_pen_follows_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && done) |=> (pen_x_reg == $past(tgt_x_reg)
                                && pen_y_reg == $past(tgt_y_reg)))
        else $error("pen not moved to line end");

endmodule

`default_nettype wire

FILE: rtl/plr_ctrl.sv
// Controller of the pen line rasterizer: idle/run state machine and the
// result valid flag. Depends on plr_pkg; drives plr_datapath.
`default_nettype none

module plr_ctrl (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire            m_ready,
    input  wire  plr_pkg::sts_t  sts,
    output plr_pkg::cmd_t  cmd
);

    typedef enum logic {IDLE, RUN} state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   slot_free;

    always_comb begin
        slot_free  = !m_valid_reg || m_ready;
        s_ready    = (state_reg == IDLE) && slot_free;
        cmd.accept = s_valid && s_ready;
        cmd.emit   = (state_reg == RUN) && slot_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (cmd.accept) begin
                        state_reg   <= sts.line_start ? RUN : IDLE;
                        m_valid_reg <= !sts.line_start;
                    end else begin
                        m_valid_reg <= m_valid_reg && !m_ready;
                    end
                end
                RUN: begin
                    if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        if (sts.done) begin
                            state_reg <= IDLE;
                        end
                    end
                end
                default: begin
                    state_reg   <= IDLE;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

    a_no_accept_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RUN) |-> !s_ready)
        else $error("input taken during a line");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !sts.line_start) |=> (m_valid && state_reg == IDLE))
        else $error("single result not presented");

    a_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.done) |=> (state_reg == IDLE && m_valid))
        else $error("line did not finish");

    a_line_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.line_start) |=> (state_reg == RUN && !m_valid))
        else $error("line did not start");

endmodule

`default_nettype wire

FILE: rtl/pen_line_rasterizer_top.sv
// Pen line rasterizer top level: Bresenham line drawing from a stored pen.
// Depends on plr_pkg, plr_ctrl and plr_datapath.
//
// Usage: each input transaction carries an action (0 move, 1 line) and a
// signed target. Targets outside the grid (cfg_wdata sets its side, capped
// at MAX_GRID) give one reject result holding the pen. A move gives one
// result with the new pen. A line gives one plot result per cell from the
// pen to the target, the last marked with m_last; the pen then moves there.
// Order: a move or reject result is valid the cycle after acceptance. A
// line enters the RUN state on acceptance; from there the Bresenham stepper
// registers one cell a cycle into the output register while that register
// is empty or being taken. One item is in work at a time.
// Stall: a result waits in the output register while m_ready is low and
// the stepper holds; s_ready is high only when idle and the output register
// is empty or being taken.
// Reset: grid side 64, pen at (0,0), no result pending.
`default_nettype none

module pen_line_rasterizer_top #(
    parameter int MAX_GRID = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [plr_pkg::GRID_W-1:0]       cfg_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_action,
    input  wire  signed [7:0]                s_target_x,
    input  wire  signed [7:0]                s_target_y,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [plr_pkg::COORD_W-1:0]      m_plot_x,
    output logic [plr_pkg::COORD_W-1:0]      m_plot_y,
    output logic [plr_pkg::STATUS_W-1:0]     m_status,
    output logic                             m_last
);

    plr_pkg::cmd_t cmd;
    plr_pkg::sts_t sts;

    plr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    plr_datapath #(
        .MAX_GRID (MAX_GRID)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_action   (s_action),
        .s_target_x (s_target_x),
        .s_target_y (s_target_y),
        .cmd        (cmd),
        .sts        (sts),
        .m_plot_x   (m_plot_x),
        .m_plot_y   (m_plot_y),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire
